FILE: rtl/anamorphic_degree4_lens_undistort_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lens undistortion block
// Concurrent assertion wrappers; defining ASSERT_OFF compiles them away.
// ----------------------------------------------------------------------------
`ifndef ANAMORPHIC_DEGREE4_LENS_UNDISTORT_DEFINES_SVH
`define ANAMORPHIC_DEGREE4_LENS_UNDISTORT_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked at every rising edge, switched off while reset is high.
`define AD4U_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every rising edge, reset included.
`define AD4U_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AD4U_ASSERT(name, clk, rst, prop, msg)
`define AD4U_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

FILE: rtl/ad4u_pkg.sv
// ----------------------------------------------------------------------------
// ad4u_pkg
// Shared constants and register codes for the degree-4 lens undistortion.
// ----------------------------------------------------------------------------
`default_nettype none

package ad4u_pkg;

  // Default field widths.
  localparam int COORD_WIDTH = 32;
  localparam int COEF_WIDTH  = 32;

  // Integer bits, sign included: coordinates are Q4.x, coefficients Q8.x.
  localparam int COORD_IBITS = 4;
  localparam int COEF_IBITS  = 8;

  // Fraction bits of the internal powers and scale factors.
  localparam int IFRAC = 32;

  localparam int NUM_REGS  = 6;
  localparam int REG_IDX_W = 3;

  // Multiplier: the wide operand is cut into limbs of this many bits.
  localparam int MUL_LIMB_W = 24;
  // Multiplier latency: partial products, then sum and round.
  localparam int MUL_LAT    = 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_COEF_X_BY_X2   = 3'd0,
    REG_COEF_X_BY_Y2   = 3'd1,
    REG_COEF_Y_BY_X2   = 3'd2,
    REG_COEF_Y_BY_Y2   = 3'd3,
    REG_COEF_X_QUARTIC = 3'd4,
    REG_COEF_Y_QUARTIC = 3'd5
  } reg_index_t;

endpackage

`default_nettype wire

FILE: rtl/ad4u_sample_if.sv
// ----------------------------------------------------------------------------
// ad4u_sample_if
// Valid/ready channel carrying one distorted point per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ad4u_sample_if #(
  parameter int COORD_WIDTH = ad4u_pkg::COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] x_in;
  logic signed [COORD_WIDTH-1:0] y_in;

  modport source (output valid, output x_in, output y_in, input ready);
  modport sink   (input valid, input x_in, input y_in, output ready);
endinterface

`default_nettype wire

FILE: rtl/ad4u_result_if.sv
// ----------------------------------------------------------------------------
// ad4u_result_if
// Valid/ready channel carrying one undistorted point per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ad4u_result_if #(
  parameter int COORD_WIDTH = ad4u_pkg::COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] x_out;
  logic signed [COORD_WIDTH-1:0] y_out;
  logic                          saturated;

  modport source (output valid, output x_out, output y_out, output saturated, input ready);
  modport sink   (input valid, input x_out, input y_out, input saturated, output ready);
endinterface

`default_nettype wire

FILE: rtl/ad4u_mul.sv
// ----------------------------------------------------------------------------
// ad4u_mul
// Two-stage signed multiplier with round-half-up and right shift. Operand b
// is cut into limbs; the first stage registers one partial product per limb,
// the second adds them with the rounding constant.
// ----------------------------------------------------------------------------
`default_nettype none

module ad4u_mul #(
  parameter int A_W    = 32,
  parameter int B_W    = 32,
  parameter int SH     = 0,
  parameter int LIMB_W = ad4u_pkg::MUL_LIMB_W
) (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic signed [A_W-1:0]     a,
  input  wire logic signed [B_W-1:0]     b,
  output logic signed [A_W+B_W-SH-1:0]   p
);

  localparam int N      = (B_W + LIMB_W - 1) / LIMB_W;
  localparam int EXT_W  = N * LIMB_W;
  localparam int PP_W   = A_W + LIMB_W + 1;
  localparam int FULL_W = A_W + B_W;
  localparam int P_W    = FULL_W - SH;
  localparam int SH_M1  = (SH > 0) ? SH - 1 : 0;
  localparam logic signed [FULL_W-1:0] RND = (SH > 0) ? (FULL_W'(1) << SH_M1) : '0;

  logic signed [EXT_W-1:0]  b_ext;
  logic signed [LIMB_W:0]   limb [N];
  logic signed [PP_W-1:0]   pp [N];
  logic signed [FULL_W-1:0] sum;
  logic signed [FULL_W-1:0] acc;

  assign b_ext = EXT_W'(b);

  // Lower limbs are unsigned; the top limb carries the sign.
  always_comb begin
    for (int k = 0; k < N; k++) begin
      if (k == N - 1) begin
        limb[k] = {b_ext[EXT_W-1], b_ext[k*LIMB_W +: LIMB_W]};
      end else begin
        limb[k] = {1'b0, b_ext[k*LIMB_W +: LIMB_W]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        pp[k] <= a * limb[k];
      end
    end
  end

  // The exact product fits in FULL_W bits, so wrapping here loses nothing.
  always_comb begin
    sum = RND;
    for (int k = 0; k < N; k++) begin
      sum = sum + (FULL_W'(pp[k]) <<< (k * LIMB_W));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc <= sum;
    end
  end

  assign p = P_W'(acc >>> SH);

endmodule

`default_nettype wire

FILE: rtl/anamorphic_degree4_lens_undistort.sv
// ----------------------------------------------------------------------------
// anamorphic_degree4_lens_undistort
// Degree-4 mixed radial and anamorphic lens undistortion of one point.
// ----------------------------------------------------------------------------
// One point enters per clock while the pipeline is not held. The pipeline
// runs as a whole: it holds when a result beat waits at the output and
// result.ready is low, and sample.ready follows that hold. The pipeline is
// built from four chained two-stage limb multipliers (squares, fourth powers
// and quadratic terms, quartic terms, final scale) plus one add stage
// after the second and third and a clamp stage at the output.
// Coefficients are Q8.x, points Q4.x; write the coefficients only while
// no beat is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "anamorphic_degree4_lens_undistort_defines.svh"

module anamorphic_degree4_lens_undistort #(
  parameter int COORD_WIDTH = ad4u_pkg::COORD_WIDTH,
  parameter int COEF_WIDTH  = ad4u_pkg::COEF_WIDTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [ad4u_pkg::REG_IDX_W-1:0]    cfg_index,
  input  wire logic [COEF_WIDTH-1:0]             cfg_data,
  ad4u_sample_if.sink                            sample,
  ad4u_result_if.source                          result
);

  localparam int IFRAC      = ad4u_pkg::IFRAC;
  localparam int MUL_LAT    = ad4u_pkg::MUL_LAT;
  localparam int COORD_FRAC = COORD_WIDTH - ad4u_pkg::COORD_IBITS;
  localparam int COEF_FRAC  = COEF_WIDTH - ad4u_pkg::COEF_IBITS;

  // Squares of a coordinate never exceed 2^(2*(COORD_IBITS-1)) in value.
  localparam int P2_W       = 2 * (ad4u_pkg::COORD_IBITS - 1) + IFRAC + 2;
  localparam int SQ_SH      = 2 * COORD_FRAC - IFRAC;
  localparam int SQ_SH_POS  = (SQ_SH > 0) ? SQ_SH : 0;
  localparam int SQ_LSH     = (SQ_SH < 0) ? -SQ_SH : 0;
  localparam int SQ_W       = 2 * COORD_WIDTH - SQ_SH_POS;
  localparam int P4_W       = 2 * P2_W - IFRAC;
  localparam int R4_W       = P4_W;
  localparam int C2_W       = COEF_WIDTH + P2_W - COEF_FRAC;
  localparam int FX_W       = COEF_WIDTH + R4_W - COEF_FRAC;
  localparam int RES_W      = COORD_WIDTH + FX_W - IFRAC;
  localparam int LAT        = 4 * MUL_LAT + 3;
  localparam int XD_N       = 3 * MUL_LAT + 2;

  localparam logic signed [FX_W-1:0]        ONE    = FX_W'(1) << IFRAC;
  localparam logic signed [COORD_WIDTH-1:0] CO_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] CO_MIN = ~CO_MAX;
  localparam logic signed [RES_W-1:0]       RES_MAX = RES_W'(CO_MAX);
  localparam logic signed [RES_W-1:0]       RES_MIN = RES_W'(CO_MIN);

  logic signed [COEF_WIDTH-1:0]  coef [ad4u_pkg::NUM_REGS];
  logic [LAT-1:0]                vld;
  logic                          advance;

  logic signed [COORD_WIDTH-1:0] x_d [XD_N];
  logic signed [COORD_WIDTH-1:0] y_d [XD_N];

  logic signed [SQ_W-1:0]  sq_x, sq_y;
  logic signed [P2_W-1:0]  x2, y2;
  logic signed [P4_W-1:0]  x4, y4, xy;
  logic signed [C2_W-1:0]  cxx, cxy, cyx, cyy;
  logic signed [R4_W-1:0]  r4;
  logic signed [FX_W-1:0]  sx, sy, sx_d1, sy_d1, sx_d2, sy_d2;
  logic signed [FX_W-1:0]  tx, ty;
  logic signed [FX_W-1:0]  fx, fy;
  logic signed [RES_W-1:0] px, py;

  logic signed [COORD_WIDTH-1:0] x_out_q, y_out_q, x_out_next, y_out_next;
  logic                          sat_q, sat_next;

  // ---- Configuration ----
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ad4u_pkg::NUM_REGS; i++) begin
        coef[i] <= '0;
      end
    end else if (cfg_we && (cfg_index < ad4u_pkg::NUM_REGS)) begin
      coef[cfg_index] <= cfg_data;
    end
  end

  // ---- Flow control: the whole pipeline holds while the output waits ----
  assign advance      = !vld[LAT-1] || result.ready;
  assign sample.ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[LAT-2:0], sample.valid};
    end
  end

  // Coordinates ride along until the final scale multiply.
  always_ff @(posedge clk) begin
    if (advance) begin
      x_d[0] <= sample.x_in;
      y_d[0] <= sample.y_in;
      for (int k = 1; k < XD_N; k++) begin
        x_d[k] <= x_d[k-1];
        y_d[k] <= y_d[k-1];
      end
    end
  end

  // ---- Squares ----
  ad4u_mul #(.A_W(COORD_WIDTH), .B_W(COORD_WIDTH), .SH(SQ_SH_POS)) u_sq_x (
    .clk(clk), .en(advance), .a(sample.x_in), .b(sample.x_in), .p(sq_x)
  );
  ad4u_mul #(.A_W(COORD_WIDTH), .B_W(COORD_WIDTH), .SH(SQ_SH_POS)) u_sq_y (
    .clk(clk), .en(advance), .a(sample.y_in), .b(sample.y_in), .p(sq_y)
  );

  // Narrow coordinates carry fewer fraction bits than IFRAC; scale up exactly.
  assign x2 = P2_W'(sq_x) <<< SQ_LSH;
  assign y2 = P2_W'(sq_y) <<< SQ_LSH;

  // ---- Fourth powers and quadratic terms ----
  ad4u_mul #(.A_W(P2_W), .B_W(P2_W), .SH(IFRAC)) u_x4 (
    .clk(clk), .en(advance), .a(x2), .b(x2), .p(x4)
  );
  ad4u_mul #(.A_W(P2_W), .B_W(P2_W), .SH(IFRAC)) u_y4 (
    .clk(clk), .en(advance), .a(y2), .b(y2), .p(y4)
  );
  ad4u_mul #(.A_W(P2_W), .B_W(P2_W), .SH(IFRAC)) u_xy (
    .clk(clk), .en(advance), .a(x2), .b(y2), .p(xy)
  );
  ad4u_mul #(.A_W(COEF_WIDTH), .B_W(P2_W), .SH(COEF_FRAC)) u_cxx (
    .clk(clk), .en(advance), .a(coef[ad4u_pkg::REG_COEF_X_BY_X2]), .b(x2), .p(cxx)
  );
  ad4u_mul #(.A_W(COEF_WIDTH), .B_W(P2_W), .SH(COEF_FRAC)) u_cxy (
    .clk(clk), .en(advance), .a(coef[ad4u_pkg::REG_COEF_X_BY_Y2]), .b(y2), .p(cxy)
  );
  ad4u_mul #(.A_W(COEF_WIDTH), .B_W(P2_W), .SH(COEF_FRAC)) u_cyx (
    .clk(clk), .en(advance), .a(coef[ad4u_pkg::REG_COEF_Y_BY_X2]), .b(x2), .p(cyx)
  );
  ad4u_mul #(.A_W(COEF_WIDTH), .B_W(P2_W), .SH(COEF_FRAC)) u_cyy (
    .clk(clk), .en(advance), .a(coef[ad4u_pkg::REG_COEF_Y_BY_Y2]), .b(y2), .p(cyy)
  );

  // ---- Radial fourth power and partial scale factors ----
  always_ff @(posedge clk) begin
    if (advance) begin
      r4 <= x4 + (xy <<< 1) + y4;
      sx <= ONE + FX_W'(cxx) + FX_W'(cxy);
      sy <= ONE + FX_W'(cyx) + FX_W'(cyy);
    end
  end

  // ---- Quartic terms ----
  ad4u_mul #(.A_W(COEF_WIDTH), .B_W(R4_W), .SH(COEF_FRAC)) u_tx (
    .clk(clk), .en(advance), .a(coef[ad4u_pkg::REG_COEF_X_QUARTIC]), .b(r4), .p(tx)
  );
  ad4u_mul #(.A_W(COEF_WIDTH), .B_W(R4_W), .SH(COEF_FRAC)) u_ty (
    .clk(clk), .en(advance), .a(coef[ad4u_pkg::REG_COEF_Y_QUARTIC]), .b(r4), .p(ty)
  );

  always_ff @(posedge clk) begin
    if (advance) begin
      sx_d1 <= sx;
      sy_d1 <= sy;
      sx_d2 <= sx_d1;
      sy_d2 <= sy_d1;
      fx    <= sx_d2 + tx;
      fy    <= sy_d2 + ty;
    end
  end

  // ---- Final scale ----
  ad4u_mul #(.A_W(COORD_WIDTH), .B_W(FX_W), .SH(IFRAC)) u_px (
    .clk(clk), .en(advance), .a(x_d[XD_N-1]), .b(fx), .p(px)
  );
  ad4u_mul #(.A_W(COORD_WIDTH), .B_W(FX_W), .SH(IFRAC)) u_py (
    .clk(clk), .en(advance), .a(y_d[XD_N-1]), .b(fy), .p(py)
  );

  // ---- Clamp to the coordinate range ----
  always_comb begin
    sat_next = 1'b0;
    if (px > RES_MAX) begin
      x_out_next = CO_MAX;
      sat_next   = 1'b1;
    end else if (px < RES_MIN) begin
      x_out_next = CO_MIN;
      sat_next   = 1'b1;
    end else begin
      x_out_next = px[COORD_WIDTH-1:0];
    end
    if (py > RES_MAX) begin
      y_out_next = CO_MAX;
      sat_next   = 1'b1;
    end else if (py < RES_MIN) begin
      y_out_next = CO_MIN;
      sat_next   = 1'b1;
    end else begin
      y_out_next = py[COORD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      x_out_q <= x_out_next;
      y_out_q <= y_out_next;
      sat_q   <= sat_next;
    end
  end

  assign result.valid     = vld[LAT-1];
  assign result.x_out     = x_out_q;
  assign result.y_out     = y_out_q;
  assign result.saturated = sat_q;

  // ---- Assertions ----
  `AD4U_ASSERT(a_hold_on_stall, clk, rst, !advance |=> $stable(vld), "pipeline moved during a stall")
  `AD4U_ASSERT(a_squares_nonneg, clk, rst, vld[MUL_LAT-1] |-> (!x2[P2_W-1] && !y2[P2_W-1]), "negative square")
  `AD4U_ASSERT(a_r4_nonneg, clk, rst, vld[2*MUL_LAT] |-> !r4[R4_W-1], "negative radial fourth power")
  `AD4U_ASSERT(a_sat_at_limit, clk, rst, (result.valid && result.saturated) |-> (result.x_out == CO_MAX || result.x_out == CO_MIN || result.y_out == CO_MAX || result.y_out == CO_MIN), "saturation flagged without a clipped result")
  `AD4U_ASSERT_ALWAYS(a_reset_empties, clk, rst |=> (vld == '0), "pipeline not empty after reset")

endmodule

`default_nettype wire
